FILE: design/stb_pkg.sv
package stb_pkg;

  // Default bank shape
  localparam int TIMER_COUNT_DEF = 16;
  localparam int TICK_WIDTH_DEF  = 32;

  // Field widths of the stream channels
  localparam int ACTION_W   = 4;
  localparam int ID_W       = 4;
  localparam int IVL_IN_W   = 32;
  localparam int VALUE_W    = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // Command codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK      = 4'd0,
    ACT_SET       = 4'd1,
    ACT_RESET     = 4'd2,
    ACT_RESTART   = 4'd3,
    ACT_CHECK     = 4'd4,
    ACT_STOP      = 4'd5,
    ACT_FORCE     = 4'd6,
    ACT_PAUSE     = 4'd7,
    ACT_CONTINUE  = 4'd8,
    ACT_REMAIN    = 4'd9,
    ACT_READ_TICK = 4'd10
  } action_t;

  // Timer status codes
  typedef enum logic [1:0] {
    ST_OFF  = 2'd0,
    ST_ON   = 2'd1,
    ST_OVER = 2'd2
  } status_t;

  // Per-command flags from the update logic to the RAM write, the tick counter and the output
  typedef struct packed {
    logic wr_en;
    logic tick_inc;
    logic expired;
  } stb_flags_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

FILE: design/stb_ram.sv
module stb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/stb_update.sv
module stb_update
  import stb_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  action_t                   action,
  input  logic                      id_ok,
  input  logic [TICK_WIDTH-1:0]     now,
  input  logic [TICK_WIDTH-1:0]     new_ivl,
  input  logic [3*TICK_WIDTH+1:0]   entry_in,
  output logic [3*TICK_WIDTH+1:0]   entry_out,
  output logic [TICK_WIDTH-1:0]     value,
  output stb_flags_t                flags
);

  localparam int TW = TICK_WIDTH;

  logic [TW-1:0] start_q;
  logic [TW-1:0] ivl_q;
  logic [TW-1:0] saved_q;
  status_t       status_q;
  logic [TW-1:0] elapsed;

  logic [TW-1:0] start_d;
  logic [TW-1:0] ivl_d;
  logic [TW-1:0] saved_d;
  status_t       status_d;

  // entry layout: start, interval, saved left, status from the low end up
  assign start_q  = entry_in[TW-1:0];
  assign ivl_q    = entry_in[2*TW-1:TW];
  assign saved_q  = entry_in[3*TW-1:2*TW];
  assign status_q = status_t'(entry_in[3*TW+1:3*TW]);
  assign elapsed  = now - start_q;

  assign entry_out = {status_d, saved_d, ivl_d, start_d};

  always_comb begin
    start_d        = start_q;
    ivl_d          = ivl_q;
    saved_d        = saved_q;
    status_d       = status_q;
    value          = '0;
    flags          = '0;
    unique case (action)
      ACT_TICK: begin
        flags.tick_inc = 1'b1;
        value          = now + 1'b1;
      end
      ACT_READ_TICK: begin
        value = now;
      end
      ACT_SET: begin
        flags.wr_en = id_ok;
        status_d    = ST_ON;
        start_d     = now;
        ivl_d       = new_ivl;
        saved_d     = '0;
      end
      ACT_RESET: begin
        flags.wr_en = id_ok;
        start_d     = start_q + ivl_q;
        status_d    = ST_ON;
      end
      ACT_RESTART: begin
        flags.wr_en = id_ok;
        start_d     = now;
        status_d    = ST_ON;
      end
      ACT_CHECK: begin
        // sticky over; compared in any status
        if (status_q == ST_OVER) begin
          flags.expired = id_ok;
        end else if (elapsed >= ivl_q) begin
          flags.wr_en   = id_ok;
          flags.expired = id_ok;
          status_d      = ST_OVER;
        end
      end
      ACT_STOP: begin
        flags.wr_en = id_ok;
        status_d    = ST_OFF;
        saved_d     = '0;
      end
      ACT_FORCE: begin
        flags.wr_en = id_ok;
        start_d     = now - ivl_q;
        status_d    = ST_OVER;
      end
      ACT_PAUSE: begin
        if (status_q == ST_ON) begin
          flags.wr_en = id_ok;
          status_d    = ST_OFF;
          saved_d     = ivl_q - elapsed;
        end
      end
      ACT_CONTINUE: begin
        if (saved_q != '0) begin
          flags.wr_en = id_ok;
          status_d    = ST_ON;
          start_d     = now;
          ivl_d       = saved_q;
          saved_d     = '0;
        end
      end
      ACT_REMAIN: begin
        if (id_ok) begin
          value = start_q + ivl_q - now;
        end
      end
      default: begin
        // unused codes: no change, zero answer
      end
    endcase
  end

endmodule

FILE: design/software_timer_bank.sv
// An accepted command is registered together with the timer RAM read; the update stage then
// writes its result into the output register, and the input is not ready until that is done.
// Each command is a read-modify-write of the timer RAM, so a new one is taken only once the last is written;
// a result held in the output register stalls the update stage and with it the input.
// Reset (rst_n, synchronous, active low) clears the tick counter, the per-timer
// valid bits and control state; an unwritten timer entry reads as all zero.
module software_timer_bank
  import stb_pkg::*;
#(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF,
  parameter int TICK_WIDTH  = TICK_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // action[3:0], timer_id[7:4], new_interval[39:8]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata  // expired[0], value[32:1], zero[39:33]
);

  localparam int TW  = TICK_WIDTH;
  localparam int AW  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int EW  = 3 * TW + 2;

  state_t                 state_r, state_nxt;
  logic [TW-1:0]          tick_r;
  logic [TIMER_COUNT-1:0] valid_r;
  logic                   rd_vld_r;
  action_t                action_r;
  logic [ID_W-1:0]        id_r;
  logic [IVL_IN_W-1:0]    ivl_in_r;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;

  logic                   in_acc;
  logic                   exec_go;
  logic [ID_W-1:0]        in_id;
  logic [AW+ID_W-1:0]     in_id_ext;
  logic [AW+ID_W-1:0]     id_ext;
  logic [AW-1:0]          raddr;
  logic [AW-1:0]          waddr;
  logic                   id_ok;
  logic [TW+IVL_IN_W-1:0] ivl_ext;
  logic [TW-1:0]          new_ivl;
  logic [EW-1:0]          ram_q;
  logic [EW-1:0]          entry;
  logic [EW-1:0]          entry_new;
  logic [TW-1:0]          value_full;
  logic [TW+VALUE_W-1:0]  value_ext;
  stb_flags_t             flags;

  function automatic logic id_ok_in(input logic [AW+ID_W-1:0] idx);
    return idx < (AW + ID_W)'(TIMER_COUNT);
  endfunction

  // address and range check from the timer id
  assign in_id     = in_tdata[7:4];
  assign in_id_ext = {{AW{1'b0}}, in_id};
  assign raddr     = in_id_ext[AW-1:0];
  assign id_ext    = {{AW{1'b0}}, id_r};
  assign waddr     = id_ext[AW-1:0];
  assign id_ok     = id_ext < (AW + ID_W)'(TIMER_COUNT);

  assign ivl_ext = {{TW{1'b0}}, ivl_in_r};
  assign new_ivl = ivl_ext[TW-1:0];

  // handshake
  assign in_acc  = in_tvalid && in_tready;
  assign exec_go = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // timer entry store
  stb_ram #(
    .WIDTH (EW),
    .DEPTH (TIMER_COUNT)
  ) u_entry_ram (
    .clk   (clk),
    .we    (exec_go && flags.wr_en),
    .waddr (waddr),
    .wdata (entry_new),
    .re    (in_acc),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // never-written entries read as the reset value
  assign entry = rd_vld_r ? ram_q : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (exec_go && flags.wr_en) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  // command capture and valid lookup alongside the RAM read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r <= action_t'(in_tdata[3:0]);
      id_r     <= in_id;
      ivl_in_r <= in_tdata[39:8];
      rd_vld_r <= id_ok_in(in_id_ext) ? valid_r[raddr] : 1'b0;
    end
  end

  stb_update #(
    .TICK_WIDTH (TW)
  ) u_update (
    .action    (action_r),
    .id_ok     (id_ok),
    .now       (tick_r),
    .new_ivl   (new_ivl),
    .entry_in  (entry),
    .entry_out (entry_new),
    .value     (value_full),
    .flags     (flags)
  );

  // tick counter, advanced only by a tick command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (exec_go && flags.tick_inc) begin
      tick_r <= tick_r + 1'b1;
    end
  end

  // output register
  assign value_ext = {{VALUE_W{1'b0}}, value_full};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_data_r <= {{(OUT_DATA_W - VALUE_W - 1){1'b0}}, value_ext[VALUE_W-1:0],
                     flags.expired};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: tb/tb_top.sv
module tb_top
  import stb_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Run limit: far beyond a correct run, which takes a few tens of microseconds
  localparam int RUN_LIMIT_NS = 2_000_000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 10;

  // Command codes with no meaning to the block
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = ACTION_W'(ACT_READ_TICK + 1);
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = '1;

  // Item layouts, lowest field last
  typedef struct packed {
    logic [IVL_IN_W-1:0] new_interval;
    logic [ID_W-1:0]     timer_id;
    logic [ACTION_W-1:0] action;
  } timer_cmd_t;

  typedef struct packed {
    logic [OUT_DATA_W-VALUE_W-2:0] pad;
    logic [VALUE_W-1:0]            value;
    logic                          expired;
  } timer_resp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Shared test control
  bit quiet = 1'b0;
  int rx_hold_reqs = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int fail_count = 0;
  timer_resp_t pending_resps[$];

  // Shadow copy of the timer bank
  logic [TICK_WIDTH_DEF-1:0] shadow_tick;
  status_t                   shadow_status [TIMER_COUNT_DEF];
  logic [TICK_WIDTH_DEF-1:0] shadow_start [TIMER_COUNT_DEF];
  logic [TICK_WIDTH_DEF-1:0] shadow_ivl [TIMER_COUNT_DEF];
  logic [TICK_WIDTH_DEF-1:0] shadow_left [TIMER_COUNT_DEF];

  software_timer_bank dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // action[3:0], timer_id[7:4], new_interval[39:8]
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)   // expired[0], value[32:1], zero[39:33]
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one command to the shadow bank and return the answer it gives
  function automatic timer_resp_t apply_timer_cmd(input timer_cmd_t c);
    timer_resp_t r;
    logic [TICK_WIDTH_DEF-1:0] now;
    logic [TICK_WIDTH_DEF-1:0] elapsed;
    logic [TICK_WIDTH_DEF-1:0] wide;
    int t;
    r = '0;
    now = shadow_tick;
    t = int'(c.timer_id);
    if (c.action == ACT_TICK) begin
      shadow_tick = shadow_tick + 1'b1;
      r.value = VALUE_W'(shadow_tick);
    end else if (c.action == ACT_READ_TICK) begin
      r.value = VALUE_W'(now);
    end else if (c.action < ACT_UNUSED_LO && t < TIMER_COUNT_DEF) begin
      elapsed = now - shadow_start[t];
      case (c.action)
        ACT_SET: begin
          shadow_status[t] = ST_ON;
          shadow_start[t] = now;
          shadow_ivl[t] = TICK_WIDTH_DEF'(c.new_interval);
          shadow_left[t] = '0;
        end
        ACT_RESET: begin
          shadow_start[t] = shadow_start[t] + shadow_ivl[t];
          shadow_status[t] = ST_ON;
        end
        ACT_RESTART: begin
          shadow_start[t] = now;
          shadow_status[t] = ST_ON;
        end
        ACT_CHECK: begin
          // compared whatever the status, so a stopped timer can expire too
          if (shadow_status[t] == ST_OVER) begin
            r.expired = 1'b1;
          end else if (elapsed >= shadow_ivl[t]) begin
            shadow_status[t] = ST_OVER;
            r.expired = 1'b1;
          end
        end
        ACT_STOP: begin
          shadow_status[t] = ST_OFF;
          shadow_left[t] = '0;
        end
        ACT_FORCE: begin
          shadow_start[t] = now - shadow_ivl[t];
          shadow_status[t] = ST_OVER;
        end
        ACT_PAUSE: begin
          if (shadow_status[t] == ST_ON) begin
            shadow_status[t] = ST_OFF;
            shadow_left[t] = shadow_ivl[t] - elapsed;
          end
        end
        ACT_CONTINUE: begin
          if (shadow_left[t] != '0) begin
            shadow_status[t] = ST_ON;
            shadow_start[t] = now;
            shadow_ivl[t] = shadow_left[t];
            shadow_left[t] = '0;
          end
        end
        default: begin
          wide = shadow_start[t] + shadow_ivl[t] - now;
          r.value = VALUE_W'(wide);
        end
      endcase
    end
    return r;
  endfunction

  function automatic timer_cmd_t make_cmd(input logic [ACTION_W-1:0] act,
                                          input int id, input logic [IVL_IN_W-1:0] ivl);
    timer_cmd_t c;
    c.action = act;
    c.timer_id = ID_W'(id);
    c.new_interval = ivl;
    return c;
  endfunction

  // Mostly well-formed traffic on a few timers, with ticks to move time on
  function automatic timer_cmd_t random_cmd();
    timer_cmd_t c;
    int r;
    int k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 99);
    c.new_interval = $urandom;
    c.timer_id = (k < 70) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom_range(0, 15));
    if (r < 30) c.action = ACT_TICK;
    else if (r < 40) c.action = ACT_SET;
    else if (r < 52) c.action = ACT_CHECK;
    else if (r < 60) c.action = ACT_REMAIN;
    else if (r < 65) c.action = ACT_RESET;
    else if (r < 70) c.action = ACT_RESTART;
    else if (r < 75) c.action = ACT_STOP;
    else if (r < 79) c.action = ACT_FORCE;
    else if (r < 85) c.action = ACT_PAUSE;
    else if (r < 91) c.action = ACT_CONTINUE;
    else if (r < 96) c.action = ACT_READ_TICK;
    else c.action = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    // short intervals so that expiry really happens within the run
    if (c.action == ACT_SET) begin
      k = $urandom_range(0, 99);
      if (k < 60) c.new_interval = $urandom_range(0, 24);
      else if (k < 75) c.new_interval = $urandom_range(0, 255);
      else if (k < 95) c.new_interval = $urandom;
      else c.new_interval = ($urandom_range(0, 1) != 0) ? '1 : '0;
    end
    return c;
  endfunction

  // Offer one item, wait for the handshake, record what should come back
  task automatic send_cmd(input timer_cmd_t c);
    while (!quiet && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    do @(posedge clk); while (!in_tready);
    pending_resps.push_back(apply_timer_cmd(c));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_resps.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_cmd(make_cmd(ACT_READ_TICK, 0, '0));
    send_cmd(make_cmd(ACT_CHECK, 5, '0));       // never armed, still compared
    send_cmd(make_cmd(ACT_TICK, 0, '0));
    send_cmd(make_cmd(ACT_SET, 0, '0));
    send_cmd(make_cmd(ACT_CHECK, 0, '0));
    send_cmd(make_cmd(ACT_SET, 15, '1));
    send_cmd(make_cmd(ACT_REMAIN, 15, '0));
    send_cmd(make_cmd(ACT_CHECK, 15, '0));
    send_cmd(make_cmd(ACT_TICK, 3, '0));
    send_cmd(make_cmd(ACT_PAUSE, 15, '0));
    send_cmd(make_cmd(ACT_REMAIN, 15, '0));
    send_cmd(make_cmd(ACT_CONTINUE, 15, '0));
    send_cmd(make_cmd(ACT_PAUSE, 1, '0));      // off: ignored
    send_cmd(make_cmd(ACT_CONTINUE, 1, '0));   // nothing saved: ignored
    send_cmd(make_cmd(ACT_SET, 2, 32'd3));
    send_cmd(make_cmd(ACT_FORCE, 2, '0));      // start wraps below zero
    send_cmd(make_cmd(ACT_CHECK, 2, '0));
    send_cmd(make_cmd(ACT_RESET, 2, '0));
    send_cmd(make_cmd(ACT_RESTART, 2, '0));
    send_cmd(make_cmd(ACT_STOP, 2, '0));
    send_cmd(make_cmd(ACT_REMAIN, 2, '0));
    send_cmd(make_cmd(ACT_UNUSED_LO, 7, 32'hAAAA_AAAA));
    send_cmd(make_cmd(ACT_UNUSED_HI, 15, 32'h5555_5555));
    send_cmd(make_cmd(ACT_READ_TICK, 15, '1));
    send_cmd(make_cmd(ACT_TICK, 15, '0));
  endtask

  task automatic test_random_mix();
    repeat (1300) send_cmd(random_cmd());
  endtask

  // Receiver holds off while items keep coming, so the input stalls
  task automatic test_receiver_stall();
    rx_hold_reqs++;
    repeat (60) send_cmd(random_cmd());
  endtask

  // Sender pauses until everything is back, then carries on
  task automatic test_drain_and_resume();
    repeat (40) send_cmd(random_cmd());
    wait_drained();
    repeat (40) send_cmd(random_cmd());
  endtask

  task automatic test_quiet_stretch();
    quiet = 1'b1;
    repeat (300) send_cmd(random_cmd());
    quiet = 1'b0;
  endtask

  // Receiver: random ready, or a counted hold-off on request
  always @(posedge clk) begin
    if (rx_hold_reqs != rx_hold_seen) begin
      rx_hold_seen = rx_hold_reqs;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(0, 2) != 0);
    end
  end

  // Compare each accepted result with the oldest outstanding answer
  always @(posedge clk) begin : resp_check
    timer_resp_t got;
    timer_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_resps.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, out_tdata);
        fail_count++;
      end else begin
        want = pending_resps.pop_front();
        if (got.expired !== want.expired) begin
          $display("%0t: expired mismatch, expected %0b, actual %0b",
                   $time, want.expired, got.expired);
          fail_count++;
        end
        if (got.value !== want.value) begin
          $display("%0t: value mismatch, expected %h, actual %h",
                   $time, want.value, got.value);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  initial begin
    shadow_tick = '0;
    foreach (shadow_status[i]) begin
      shadow_status[i] = ST_OFF;
      shadow_start[i] = '0;
      shadow_ivl[i] = '0;
      shadow_left[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix();
    test_receiver_stall();
    test_drain_and_resume();
    test_quiet_stretch();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
